// ----- sv/tcfla_pkg.sv -----
// Package for the two-class free-list allocator.
// Widths of the beat fields, status codes and sequencer states; no dependencies.
package tcfla_pkg;

  localparam int MAX_SERVERS_DEF = 1024;
  localparam int ID_W            = 10;
  localparam int CNT_W           = 11;
  localparam int STATUS_W        = 2;

  // Class codes
  localparam logic LINUX   = 1'b0;
  localparam logic WINDOWS = 1'b1;

  // Request codes
  localparam logic REQ_ALLOC = 1'b0;
  localparam logic REQ_FREE  = 1'b1;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK           = 2'd0,
    ST_NONE_FREE    = 2'd1,
    ST_INVALID      = 2'd2,
    ST_ALREADY_FREE = 2'd3
  } status_t;

  typedef enum logic [8:0] {
    S_CLR  = 9'b000000001,
    S_IDLE = 9'b000000010,
    S_WID  = 9'b000000100,
    S_RVIC = 9'b000001000,
    S_GWR  = 9'b000010000,
    S_GP   = 9'b000100000,
    S_GN   = 9'b001000000,
    S_FT   = 9'b010000000,
    S_OUT  = 9'b100000000
  } state_t;

endpackage

// ----- sv/tcfla_ram.sv -----
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module tcfla_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

// ----- sv/two_class_free_list_allocator.sv -----
// Two-class free-list allocator, top level.
// Depends on tcfla_pkg and tcfla_ram.
//
// Hands out numbered resources, each free one queued on one of two FIFO free
// lists (class 0 linux, class 1 windows) kept as doubly linked lists in a single
// record RAM of MAX_SERVERS entries {taken, class, next, prev}. One beat in
// gives one beat out. All list surgery goes through the one RAM port pair under
// a small sequencer, so the block takes one beat at a time: a none-free or range
// error goes straight to S_OUT; a free passes S_WID, and S_FT if its list was
// not empty; a request passes S_WID, S_RVIC (if served from a list head), S_GWR,
// S_GP and S_GN; S_OUT waits while a stalled earlier beat holds the result.
// After reset and every cfg_server_count write the RAM is rebuilt by a sweep,
// one entry a cycle, with in_stall high. Writes above MAX_SERVERS are clamped.
module two_class_free_list_allocator
  import tcfla_pkg::*;
#(
  parameter int MAX_SERVERS = MAX_SERVERS_DEF
) (
  input  logic                clk,
  input  logic                rst_n,
  // request beats
  input  logic                in_valid,
  output logic                in_stall,
  input  logic                in_req_type,
  input  logic [ID_W-1:0]     in_server_id,
  input  logic                in_os_class,
  // result beats
  output logic                out_valid,
  input  logic                out_stall,
  output logic [ID_W-1:0]     out_assigned_id,
  output logic                out_class_changed,
  output logic [STATUS_W-1:0] out_status,
  output logic [CNT_W-1:0]    out_linux_count,
  output logic [CNT_W-1:0]    out_windows_count,
  // configuration
  input  logic                cfg_we,
  input  logic [CNT_W-1:0]    cfg_server_count
);

  localparam int IW   = $clog2(MAX_SERVERS);
  localparam int LW   = IW + 1;                 // link width, NIL = MAX_SERVERS
  localparam int RW   = 2 + 2 * LW;             // record width
  localparam int CMPW = (LW > CNT_W) ? LW : CNT_W;
  localparam logic [LW-1:0] NIL = LW'(MAX_SERVERS);

  // record field positions
  localparam int R_TAKEN = RW - 1;
  localparam int R_CLS   = RW - 2;

  state_t state_r, state_nxt;

  logic [LW-1:0] count_r, count_nxt;          // server_count, clamped
  logic [LW-1:0] free_r, free_nxt;
  logic [LW-1:0] c0_r, c0_nxt;
  logic [LW-1:0] c1_r, c1_nxt;
  logic [LW-1:0] head_r [2];
  logic [LW-1:0] tail_r [2];
  logic [LW-1:0] head_nxt [2];
  logic [LW-1:0] tail_nxt [2];
  logic [IW-1:0] clr_r, clr_nxt;

  // working registers of the beat in flight
  logic          req_r, req_nxt;
  logic [ID_W-1:0] id_r, id_nxt;
  logic          want_r, want_nxt;
  logic [LW-1:0] vic_r, vic_nxt;               // granted id, or tail on a free
  logic [RW-1:0] vrec_r, vrec_nxt;
  logic          chg_r, chg_nxt;
  status_t       sts_r, sts_nxt;

  // result register
  logic            ov_r, ov_nxt;
  logic [ID_W-1:0] o_id_r, o_id_nxt;
  logic            o_chg_r, o_chg_nxt;
  status_t         o_sts_r, o_sts_nxt;
  logic [CNT_W-1:0] o_c0_r, o_c0_nxt;
  logic [CNT_W-1:0] o_c1_r, o_c1_nxt;

  // RAM port
  logic          ram_we;
  logic [IW-1:0] ram_waddr, ram_raddr;
  logic [RW-1:0] ram_wdata, ram_rdata;

  tcfla_ram #(
    .WIDTH(RW),
    .DEPTH(MAX_SERVERS)
  ) u_rec (
    .clk  (clk),
    .we   (ram_we),
    .waddr(ram_waddr),
    .wdata(ram_wdata),
    .raddr(ram_raddr),
    .rdata(ram_rdata)
  );

  // record fields
  logic          rd_taken, rd_cls;
  logic [LW-1:0] rd_next, rd_prev;
  logic          v_cls;
  logic [LW-1:0] v_next, v_prev;
  assign rd_taken = ram_rdata[R_TAKEN];
  assign rd_cls   = ram_rdata[R_CLS];
  assign rd_next  = ram_rdata[2*LW-1:LW];
  assign rd_prev  = ram_rdata[LW-1:0];
  assign v_cls    = vrec_r[R_CLS];
  assign v_next   = vrec_r[2*LW-1:LW];
  assign v_prev   = vrec_r[LW-1:0];

  // compare helpers
  logic [CMPW-1:0] in_id_ext, cnt_ext, cfg_ext, max_ext;
  logic [LW-1:0]   clr_ext, clr_inc, clr_dec, cfg_clamped;
  logic [LW-1:0]   pick;
  logic            out_free;
  assign in_id_ext   = CMPW'(in_server_id);
  assign cnt_ext     = CMPW'(count_r);
  assign cfg_ext     = CMPW'(cfg_server_count);
  assign max_ext     = CMPW'(MAX_SERVERS);
  assign cfg_clamped = (cfg_ext > max_ext) ? NIL : LW'(cfg_ext);
  assign clr_ext     = LW'(clr_r);
  assign clr_inc     = clr_ext + LW'(1);
  assign clr_dec     = clr_ext - LW'(1);
  // head of the wanted list, else head of the other one
  assign pick        = (head_r[want_r] != NIL) ? head_r[want_r] : head_r[~want_r];
  assign out_free    = !ov_r || !out_stall;

  always_comb begin
    state_nxt   = state_r;
    count_nxt   = count_r;
    free_nxt    = free_r;
    c0_nxt      = c0_r;
    c1_nxt      = c1_r;
    head_nxt    = head_r;
    tail_nxt    = tail_r;
    clr_nxt     = clr_r;
    req_nxt     = req_r;
    id_nxt      = id_r;
    want_nxt    = want_r;
    vic_nxt     = vic_r;
    vrec_nxt    = vrec_r;
    chg_nxt     = chg_r;
    sts_nxt     = sts_r;
    ov_nxt      = ov_r && out_stall;
    o_id_nxt    = o_id_r;
    o_chg_nxt   = o_chg_r;
    o_sts_nxt   = o_sts_r;
    o_c0_nxt    = o_c0_r;
    o_c1_nxt    = o_c1_r;
    ram_we      = 1'b0;
    ram_waddr   = IW'(id_r);
    ram_wdata   = '0;
    ram_raddr   = IW'(id_r);

    unique case (state_r)
      S_CLR: begin
        ram_we    = 1'b1;
        ram_waddr = clr_r;
        ram_wdata = {1'b0, LINUX,
                     (clr_inc < count_r) ? clr_inc : NIL,
                     (clr_r != '0 && clr_ext < count_r) ? clr_dec : NIL};
        clr_nxt   = clr_r + IW'(1);
        if (clr_r == IW'(MAX_SERVERS - 1)) begin
          state_nxt = S_IDLE;
        end
      end
      S_IDLE: begin
        ram_raddr = IW'(in_server_id);
        if (in_valid) begin
          req_nxt  = in_req_type;
          id_nxt   = in_server_id;
          want_nxt = in_os_class;
          chg_nxt  = 1'b0;
          vic_nxt  = '0;
          sts_nxt  = ST_OK;
          if (in_req_type == REQ_ALLOC && free_r == '0) begin
            sts_nxt   = ST_NONE_FREE;
            state_nxt = S_OUT;
          end else if (in_id_ext >= cnt_ext) begin
            sts_nxt   = ST_INVALID;
            state_nxt = S_OUT;
          end else begin
            state_nxt = S_WID;
          end
        end
      end
      S_WID: begin
        if (req_r == REQ_ALLOC) begin
          if (!rd_taken) begin
            vic_nxt   = LW'(id_r);
            vrec_nxt  = ram_rdata;
            state_nxt = S_GWR;
          end else begin
            vic_nxt   = pick;
            ram_raddr = IW'(pick);
            state_nxt = S_RVIC;
          end
        end else if (!rd_taken) begin
          sts_nxt   = ST_ALREADY_FREE;
          state_nxt = S_OUT;
        end else begin
          // append at the tail of its own class list
          ram_we    = 1'b1;
          ram_wdata = {1'b0, rd_cls, NIL, tail_r[rd_cls]};
          ram_raddr = IW'(tail_r[rd_cls]);
          vic_nxt   = tail_r[rd_cls];
          if (tail_r[rd_cls] == NIL) begin
            head_nxt[rd_cls] = LW'(id_r);
            state_nxt        = S_OUT;
          end else begin
            state_nxt = S_FT;
          end
          tail_nxt[rd_cls] = LW'(id_r);
          free_nxt         = free_r + LW'(1);
        end
      end
      S_RVIC: begin
        vrec_nxt  = ram_rdata;
        state_nxt = S_GWR;
      end
      S_GWR: begin
        ram_we    = 1'b1;
        ram_waddr = IW'(vic_r);
        ram_wdata = {1'b1, want_r, NIL, NIL};
        ram_raddr = IW'(v_prev);
        if (v_prev == NIL) head_nxt[v_cls] = v_next;
        if (v_next == NIL) tail_nxt[v_cls] = v_prev;
        free_nxt = free_r - LW'(1);
        if (v_cls != want_r) begin
          chg_nxt = 1'b1;
          if (want_r == WINDOWS) begin
            c0_nxt = c0_r - LW'(1);
            c1_nxt = c1_r + LW'(1);
          end else begin
            c1_nxt = c1_r - LW'(1);
            c0_nxt = c0_r + LW'(1);
          end
        end
        state_nxt = S_GP;
      end
      S_GP: begin
        ram_we    = (v_prev != NIL);
        ram_waddr = IW'(v_prev);
        ram_wdata = {ram_rdata[RW-1:2*LW], v_next, rd_prev};
        ram_raddr = IW'(v_next);
        state_nxt = S_GN;
      end
      S_GN: begin
        ram_we    = (v_next != NIL);
        ram_waddr = IW'(v_next);
        ram_wdata = {ram_rdata[RW-1:LW], v_prev};
        state_nxt = S_OUT;
      end
      S_FT: begin
        ram_we    = 1'b1;
        ram_waddr = IW'(vic_r);
        ram_wdata = {ram_rdata[RW-1:2*LW], LW'(id_r), rd_prev};
        state_nxt = S_OUT;
      end
      S_OUT: begin
        if (out_free) begin
          ov_nxt    = 1'b1;
          o_sts_nxt = sts_r;
          o_id_nxt  = (sts_r == ST_OK && req_r == REQ_ALLOC) ? ID_W'(vic_r) : '0;
          o_chg_nxt = (sts_r == ST_OK) ? chg_r : 1'b0;
          o_c0_nxt  = CNT_W'(c0_r);
          o_c1_nxt  = CNT_W'(c1_r);
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_CLR;
    endcase

    // register write: rebuild everything (the user writes only while idle; the block does not enforce it)
    if (cfg_we) begin
      count_nxt   = cfg_clamped;
      free_nxt    = cfg_clamped;
      c0_nxt      = cfg_clamped;
      c1_nxt      = '0;
      head_nxt[0] = (cfg_clamped != '0) ? '0 : NIL;
      tail_nxt[0] = (cfg_clamped != '0) ? cfg_clamped - LW'(1) : NIL;
      head_nxt[1] = NIL;
      tail_nxt[1] = NIL;
      clr_nxt     = '0;
      state_nxt   = S_CLR;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= S_CLR;
      count_r   <= NIL;
      free_r    <= NIL;
      c0_r      <= NIL;
      c1_r      <= '0;
      head_r[0] <= '0;
      tail_r[0] <= NIL - LW'(1);
      head_r[1] <= NIL;
      tail_r[1] <= NIL;
      clr_r     <= '0;
      ov_r      <= 1'b0;
    end else begin
      state_r <= state_nxt;
      count_r <= count_nxt;
      free_r  <= free_nxt;
      c0_r    <= c0_nxt;
      c1_r    <= c1_nxt;
      head_r  <= head_nxt;
      tail_r  <= tail_nxt;
      clr_r   <= clr_nxt;
      ov_r    <= ov_nxt;
    end
  end

  always_ff @(posedge clk) begin
    req_r   <= req_nxt;
    id_r    <= id_nxt;
    want_r  <= want_nxt;
    vic_r   <= vic_nxt;
    vrec_r  <= vrec_nxt;
    chg_r   <= chg_nxt;
    sts_r   <= sts_nxt;
    o_id_r  <= o_id_nxt;
    o_chg_r <= o_chg_nxt;
    o_sts_r <= o_sts_nxt;
    o_c0_r  <= o_c0_nxt;
    o_c1_r  <= o_c1_nxt;
  end

  assign in_stall          = (state_r != S_IDLE);
  assign out_valid         = ov_r;
  assign out_assigned_id   = o_id_r;
  assign out_class_changed = o_chg_r;
  assign out_status        = o_sts_r;
  assign out_linux_count   = o_c0_r;
  assign out_windows_count = o_c1_r;

endmodule

// ----- sv/tcfla_chk.sv -----
// Port-level checker for the two-class free-list allocator, with its bind.
// Depends on tcfla_pkg.
module tcfla_chk
  import tcfla_pkg::*;
(
  input logic                clk,
  input logic                rst_n,
  input logic                in_valid,
  input logic                in_stall,
  input logic                out_valid,
  input logic                out_stall,
  input logic [ID_W-1:0]     out_assigned_id,
  input logic                out_class_changed,
  input logic [STATUS_W-1:0] out_status,
  input logic                cfg_we
);

  // failed beats carry no grant
  a_err_clean: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_status != ST_OK |-> out_assigned_id == '0 && !out_class_changed)
    else $error("error beat carries a grant");

  // conversion only on a good beat
  a_chg_ok: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_class_changed |-> out_status == ST_OK)
    else $error("class change on failed beat");

  // one beat at a time: busy right after an accept
  a_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall |=> in_stall)
    else $error("accepted back to back");

  // a register write starts the rebuild sweep
  a_sweep: assert property (@(posedge clk) disable iff (!rst_n)
    cfg_we |=> in_stall)
    else $error("not rebuilding after write");

  // stalled result holds
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_status)
      && $stable(out_assigned_id))
    else $error("stalled result changed");

endmodule

bind two_class_free_list_allocator tcfla_chk u_tcfla_chk (
  .clk              (clk),
  .rst_n            (rst_n),
  .in_valid         (in_valid),
  .in_stall         (in_stall),
  .out_valid        (out_valid),
  .out_stall        (out_stall),
  .out_assigned_id  (out_assigned_id),
  .out_class_changed(out_class_changed),
  .out_status       (out_status),
  .cfg_we           (cfg_we)
);

// ----- tb/sv/tb_two_class_free_list_allocator.sv -----
// Testbench for the two-class free-list allocator: directed and random beats
// checked against a behavioural model of the two free lists.
// Depends on tcfla_pkg and the two_class_free_list_allocator RTL.
`timescale 1ns / 1ps

module tb_two_class_free_list_allocator;
  import tcfla_pkg::*;

  localparam int NIL       = MAX_SERVERS_DEF;
  localparam int RUN_LIMIT = 600000;

  typedef struct {
    logic [ID_W-1:0]  id;
    logic             changed;
    status_t          st;
    logic [CNT_W-1:0] lin_cnt;
    logic [CNT_W-1:0] win_cnt;
  } grant_result_t;

  // Free-list model plus the queue of answers still owed by the block.
  class alloc_scoreboard;
    int            n_servers;
    bit            taken[MAX_SERVERS_DEF];
    bit            cls[MAX_SERVERS_DEF];
    int            nxt[MAX_SERVERS_DEF];
    int            prv[MAX_SERVERS_DEF];
    int            head[2];
    int            tail[2];
    int            n_free, n_lin, n_win;
    grant_result_t owed[$];
    int            errors, beats_in, beats_out;

    function void rebuild(int cnt);
      if (cnt > MAX_SERVERS_DEF) cnt = MAX_SERVERS_DEF;
      n_servers = cnt;
      for (int i = 0; i < MAX_SERVERS_DEF; i++) begin
        taken[i] = 0;
        cls[i]   = LINUX;
        nxt[i]   = (i + 1 < cnt) ? i + 1 : NIL;
        prv[i]   = (i > 0 && i < cnt) ? i - 1 : NIL;
      end
      head[0] = cnt ? 0 : NIL;
      tail[0] = cnt ? cnt - 1 : NIL;
      head[1] = NIL;
      tail[1] = NIL;
      n_free  = cnt;
      n_lin   = cnt;
      n_win   = 0;
    endfunction

    function void unlink(int id, int c);
      int p, n;
      p = prv[id];
      n = nxt[id];
      if (p == NIL) head[c] = n; else nxt[p] = n;
      if (n == NIL) tail[c] = p; else prv[n] = p;
      nxt[id] = NIL;
      prv[id] = NIL;
    endfunction

    // take a free resource and convert it if needed; 1 when converted
    function bit take(int id, bit want);
      bit was;
      was = cls[id];
      unlink(id, was);
      taken[id] = 1;
      n_free--;
      if (was == want) return 0;
      cls[id] = want;
      if (want == WINDOWS) begin
        n_lin--; n_win++;
      end else begin
        n_win--; n_lin++;
      end
      return 1;
    endfunction

    function void note_beat(bit req, int id, bit want);
      grant_result_t r;
      r.id      = '0;
      r.changed = 0;
      r.st      = ST_OK;
      beats_in++;
      if (req == REQ_ALLOC) begin
        if (n_free == 0 || (head[0] == NIL && head[1] == NIL)) r.st = ST_NONE_FREE;
        else if (id >= n_servers) r.st = ST_INVALID;
        else begin
          int pick;
          if (!taken[id]) pick = id;
          else if (head[want] != NIL) pick = head[want];
          else pick = head[!want];
          r.id      = ID_W'(pick);
          r.changed = take(pick, want);
        end
      end else begin
        if (id >= n_servers) r.st = ST_INVALID;
        else if (!taken[id]) r.st = ST_ALREADY_FREE;
        else begin
          taken[id] = 0;
          prv[id] = tail[cls[id]];
          nxt[id] = NIL;
          if (tail[cls[id]] == NIL) head[cls[id]] = id; else nxt[tail[cls[id]]] = id;
          tail[cls[id]] = id;
          n_free++;
        end
      end
      r.lin_cnt = CNT_W'(n_lin);
      r.win_cnt = CNT_W'(n_win);
      owed.push_back(r);
    endfunction

    function void check_beat(grant_result_t got);
      grant_result_t e;
      beats_out++;
      if (owed.size() == 0) begin
        $error("result beat with nothing owed");
        errors++;
        return;
      end
      e = owed.pop_front();
      if (got.id != e.id) begin
        $error("assigned_id: expected %0d, got %0d", e.id, got.id); errors++;
      end
      if (got.changed != e.changed) begin
        $error("class_changed: expected %0d, got %0d", e.changed, got.changed); errors++;
      end
      if (got.st != e.st) begin
        $error("status: expected %0d, got %0d", e.st, got.st); errors++;
      end
      if (got.lin_cnt != e.lin_cnt) begin
        $error("linux_count: expected %0d, got %0d", e.lin_cnt, got.lin_cnt); errors++;
      end
      if (got.win_cnt != e.win_cnt) begin
        $error("windows_count: expected %0d, got %0d", e.win_cnt, got.win_cnt); errors++;
      end
    endfunction
  endclass

  logic                clk;
  logic                rst_n;
  logic                in_valid;
  logic                in_stall;
  logic                in_req_type;
  logic [ID_W-1:0]     in_server_id;
  logic                in_os_class;
  logic                out_valid;
  logic                out_stall;
  logic [ID_W-1:0]     out_assigned_id;
  logic                out_class_changed;
  logic [STATUS_W-1:0] out_status;
  logic [CNT_W-1:0]    out_linux_count;
  logic [CNT_W-1:0]    out_windows_count;
  logic                cfg_we;
  logic [CNT_W-1:0]    cfg_server_count;

  alloc_scoreboard sb;
  int send_idle_pct;   // chance per cycle that the sender holds back
  int recv_idle_pct;   // chance per cycle that the receiver stalls
  int cycles;

  two_class_free_list_allocator u_top (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_valid          (in_valid),
    .in_stall          (in_stall),
    .in_req_type       (in_req_type),
    .in_server_id      (in_server_id),
    .in_os_class       (in_os_class),
    .out_valid         (out_valid),
    .out_stall         (out_stall),
    .out_assigned_id   (out_assigned_id),
    .out_class_changed (out_class_changed),
    .out_status        (out_status),
    .out_linux_count   (out_linux_count),
    .out_windows_count (out_windows_count),
    .cfg_we            (cfg_we),
    .cfg_server_count  (cfg_server_count)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  // Watchdog: a hung handshake ends the run here.
  initial cycles = 0;
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > RUN_LIMIT) begin
      $display("two_class_free_list_allocator regression: fail");
      $finish;
    end
  end

  // Receiver: stall is redrawn every rising edge; outputs are stable by the falling
  // edge, so a beat seen there with stall low is taken on the next rising edge.
  always @(posedge clk) begin
    if (!rst_n) out_stall <= 1'b0;
    else        out_stall <= ($urandom_range(99) < recv_idle_pct);
  end

  always @(negedge clk) begin
    grant_result_t got;
    if (rst_n && out_valid && !out_stall) begin
      got.id      = out_assigned_id;
      got.changed = out_class_changed;
      got.st      = status_t'(out_status);
      got.lin_cnt = out_linux_count;
      got.win_cnt = out_windows_count;
      sb.check_beat(got);
    end
  end

  // Drive one request beat and hold it until it is taken. Called at a rising
  // edge; returns at the edge that took the beat, valid still high.
  task automatic send_beat(bit req, int id, bit want);
    bit took;
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid     <= 1'b1;
    in_req_type  <= req;
    in_server_id <= id[ID_W-1:0];
    in_os_class  <= want;
    do begin
      @(negedge clk);
      took = !in_stall;
      @(posedge clk);
    end while (!took);
    sb.note_beat(req, id, want);
  endtask

  // Let every owed answer come back with the input channel quiet.
  task automatic drain();
    in_valid <= 1'b0;
    while (sb.owed.size() != 0) @(posedge clk);
    repeat (10) @(posedge clk);
  endtask

  // Register write only while the block is idle; the RTL sweeps its RAM after.
  task automatic set_server_count(int val);
    drain();
    cfg_we           <= 1'b1;
    cfg_server_count <= val[CNT_W-1:0];
    @(posedge clk);
    cfg_we <= 1'b0;
    sb.rebuild(val);
  endtask

  // Random beats: mostly in-range ids, frees aimed at taken ones half the time.
  task automatic random_beats(int n);
    for (int k = 0; k < n; k++) begin
      bit req;
      int id;
      req = 1'($urandom_range(1));
      if ($urandom_range(9) == 0 || sb.n_servers == 0) id = $urandom_range(MAX_SERVERS_DEF - 1);
      else id = $urandom_range(sb.n_servers - 1);
      if (req == REQ_FREE && $urandom_range(1) && sb.n_servers != 0) begin
        for (int t = 0; t < 8 && !sb.taken[id]; t++) id = $urandom_range(sb.n_servers - 1);
      end
      send_beat(req, id, 1'($urandom_range(1)));
    end
  endtask

  initial begin
    sb = new();
    sb.rebuild(MAX_SERVERS_DEF);
    send_idle_pct    = 38;
    recv_idle_pct    = 68;
    rst_n            = 1'b0;
    in_valid         = 1'b0;
    in_req_type      = REQ_ALLOC;
    in_server_id     = '0;
    in_os_class      = LINUX;
    out_stall        = 1'b0;
    cfg_we           = 1'b0;
    cfg_server_count = '0;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed: full pool after reset, preferred id, both list heads, conversion.
    send_beat(REQ_ALLOC, 0, LINUX);
    send_beat(REQ_ALLOC, 1023, WINDOWS);     // preferred id free, converted
    send_beat(REQ_ALLOC, 0, WINDOWS);        // taken, windows list empty: linux head
    send_beat(REQ_FREE, 1023, LINUX);        // joins the windows list
    send_beat(REQ_ALLOC, 0, WINDOWS);        // served from the windows head
    send_beat(REQ_FREE, 1023, LINUX);
    send_beat(REQ_FREE, 1023, LINUX);        // freeing a free resource
    send_beat(REQ_FREE, 0, WINDOWS);
    send_beat(REQ_ALLOC, 682, WINDOWS);
    send_beat(REQ_ALLOC, 341, LINUX);

    // Tiny pool: out-of-range ids, then exhaust it.
    set_server_count(3);
    send_beat(REQ_ALLOC, 1023, LINUX);       // id out of range
    send_beat(REQ_FREE, 1023, LINUX);        // id out of range
    send_beat(REQ_ALLOC, 2, WINDOWS);
    send_beat(REQ_ALLOC, 2, WINDOWS);
    send_beat(REQ_ALLOC, 2, LINUX);
    send_beat(REQ_ALLOC, 1023, LINUX);       // nothing free beats the range check
    send_beat(REQ_FREE, 2, LINUX);

    // Empty pool.
    set_server_count(0);
    send_beat(REQ_ALLOC, 0, LINUX);
    send_beat(REQ_FREE, 0, LINUX);

    // Oversized count is clamped to the full pool.
    set_server_count(2047);
    send_beat(REQ_ALLOC, 1023, WINDOWS);
    send_beat(REQ_FREE, 1023, LINUX);

    // Random phases; idling pattern flips, then goes away.
    set_server_count(16);
    random_beats(600);
    send_idle_pct = 68;
    recv_idle_pct = 38;
    set_server_count(1024);
    random_beats(450);
    set_server_count(5);
    random_beats(300);
    send_idle_pct = 0;
    recv_idle_pct = 0;
    set_server_count(1);
    random_beats(100);
    set_server_count(1000);
    random_beats(450);

    drain();
    $display("Covered %0d request beats and %0d result beats over pool sizes 0 to 1024,",
             sb.beats_in, sb.beats_out);
    $display("with both idling patterns and a stretch of full-rate traffic.");
    if (sb.errors == 0) begin
      $display("two_class_free_list_allocator regression: pass");
    end else begin
      $display("two_class_free_list_allocator regression: fail");
    end
    $finish;
  end

endmodule
